>>> hdl/mmpn_pkg.sv
// mmpn_pkg: shared constants and types for the min-max point normaliser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mmpn_pkg;
    localparam int COORD_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int NUM_AXES      = 3;
    localparam int AXIS_W        = 2;

    localparam logic [0:0] REG_TARGET_LOW  = 1'b0;
    localparam logic [0:0] REG_TARGET_HIGH = 1'b1;

    localparam logic MODE_MEASURE = 1'b0;
    localparam logic MODE_SCALE   = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic       measure;    // fold input point into min/max
        logic       latch;      // capture input point for scaling
        logic       mul_start;  // form product for current axis
        logic       div_start;  // start divider on current axis
        logic       div_step;   // one quotient bit
        logic       finish;     // write result of current axis
        logic [1:0] axis;
    } mmpn_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
    } mmpn_stat_t;
endpackage
`default_nettype wire

>>> hdl/mmpn_ctrl.sv
// mmpn_ctrl: sequencer for measure and scale words
// depends on mmpn_pkg
`timescale 1ns / 1ps
`default_nettype none
module mmpn_ctrl
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    input  wire                    in_mode,
    output logic                   in_ready,
    input  wire                    out_busy,
    output logic                   out_load,
    input  wire mmpn_pkg::mmpn_stat_t stat,
    output mmpn_pkg::mmpn_cmd_t    cmd
);
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIVS = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_mode == mmpn_pkg::MODE_MEASURE)
                        cmd.measure = 1'b1;
                    else
                    begin
                        cmd.latch  = 1'b1;
                        axis_next  = 2'd0;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul_start = 1'b1;
                state_next    = ST_DIVS;
            end
            ST_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.finish = 1'b1;
                    if (axis_reg == 2'd2)
                        state_next = ST_OUT;
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = ST_MUL;
                    end
                end
                else
                    cmd.div_step = 1'b1;
            end
            ST_OUT:
            begin
                if (!out_busy)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> hdl/mmpn_dp.sv
// mmpn_dp: min/max tracking, product, shared restoring divider, saturation
// depends on mmpn_pkg
`timescale 1ns / 1ps
`default_nettype none
module mmpn_dp #(
    parameter int COORD_WIDTH = mmpn_pkg::COORD_WIDTH
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire mmpn_pkg::mmpn_cmd_t     cmd,
    output mmpn_pkg::mmpn_stat_t         stat,
    input  wire signed [COORD_WIDTH-1:0] px,
    input  wire signed [COORD_WIDTH-1:0] py,
    input  wire signed [COORD_WIDTH-1:0] pz,
    input  wire signed [COORD_WIDTH-1:0] tlow,
    input  wire signed [COORD_WIDTH-1:0] thigh,
    output logic [3*COORD_WIDTH-1:0]     res,
    output logic [2:0]                   deg,
    output logic [2:0]                   sat
);
    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;          // span / difference width
    localparam int PW = 2 * DW;          // product magnitude width
    localparam int CNT_W = $clog2(PW + 1);

    logic signed [CW-1:0] lo_reg [3];
    logic signed [CW-1:0] hi_reg [3];
    logic signed [CW-1:0] pt_reg [3];
    logic [CW-1:0]        res_reg [3];
    logic [2:0]           deg_reg, sat_reg;
    logic                 nonempty_reg, prev_scale_reg;

    logic [PW-1:0]    num_reg;      // shifts out dividend, shifts in quotient
    logic [DW:0]      rem_reg;
    logic [DW-1:0]    den_reg;
    logic             neg_reg, dg_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic signed [CW-1:0] pin [3];
    assign pin[0] = px;
    assign pin[1] = py;
    assign pin[2] = pz;

    logic signed [DW-1:0] d1, d2, span;
    logic [DW-1:0]        m1, m2;
    logic                 degen;
    assign d1   = DW'(pt_reg[cmd.axis]) - DW'(lo_reg[cmd.axis]);
    assign d2   = DW'(thigh) - DW'(tlow);
    assign span = DW'(hi_reg[cmd.axis]) - DW'(lo_reg[cmd.axis]);
    assign m1   = d1[DW-1] ? DW'(-d1) : d1;
    assign m2   = d2[DW-1] ? DW'(-d2) : d2;
    assign degen = !nonempty_reg || span[DW-1] || (span == '0);

    logic [DW:0] rsh, rsub;
    assign rsh  = {rem_reg[DW-1:0], num_reg[PW-1]};
    assign rsub = rsh - {1'b0, den_reg};

    // final sum: target low plus or minus the quotient, then clip; target low on a degenerate axis
    logic                 qbig;
    logic signed [DW+1:0] sum;
    logic [CW-1:0]        fin;
    logic                 fsat;
    localparam logic signed [DW+1:0] MAXV = (DW+2)'((64'sd1 <<< (CW-1)) - 1);
    localparam logic signed [DW+1:0] MINV = -(DW+2)'(64'sd1 <<< (CW-1));
    always_comb
    begin
        qbig = |num_reg[PW-1:DW];
        sum  = neg_reg ? (DW+2)'(tlow) - (DW+2)'({1'b0, num_reg[DW-1:0]})
                       : (DW+2)'(tlow) + (DW+2)'({1'b0, num_reg[DW-1:0]});
        fsat = 1'b0;
        fin  = sum[CW-1:0];
        if (dg_reg)
            fin = tlow;
        else if (qbig || sum > MAXV || sum < MINV)
        begin
            fsat = 1'b1;
            fin  = neg_reg ? MINV[CW-1:0] : MAXV[CW-1:0];
        end
    end

    assign stat.div_done = (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg   <= 1'b0;
            prev_scale_reg <= 1'b1;
            cnt_reg        <= '0;
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i] <= '0;
                hi_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.measure)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (prev_scale_reg || !nonempty_reg)
                    begin
                        lo_reg[i] <= pin[i];
                        hi_reg[i] <= pin[i];
                    end
                    else
                    begin
                        if (pin[i] < lo_reg[i]) lo_reg[i] <= pin[i];
                        if (pin[i] > hi_reg[i]) hi_reg[i] <= pin[i];
                    end
                end
                nonempty_reg   <= 1'b1;
                prev_scale_reg <= 1'b0;
            end
            if (cmd.latch)
                prev_scale_reg <= 1'b1;
            if (cmd.div_start)
                cnt_reg <= dg_reg ? '0 : CNT_W'(PW);
            else if (cmd.div_step)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            for (int i = 0; i < 3; i++)
                pt_reg[i] <= pin[i];
            deg_reg <= '0;
            sat_reg <= '0;
        end
        if (cmd.mul_start)
        begin
            num_reg <= m1 * m2;
            neg_reg <= d1[DW-1] ^ d2[DW-1];
            den_reg <= span;
            dg_reg  <= degen;
        end
        if (cmd.div_start)
            rem_reg <= '0;
        if (cmd.div_step)
        begin
            if (!rsub[DW])
            begin
                rem_reg <= rsub;
                num_reg <= {num_reg[PW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rsh;
                num_reg <= {num_reg[PW-2:0], 1'b0};
            end
        end
        if (cmd.finish)
        begin
            res_reg[cmd.axis] <= fin;
            deg_reg[cmd.axis] <= dg_reg;
            sat_reg[cmd.axis] <= fsat;
        end
    end

    assign res = {res_reg[2], res_reg[1], res_reg[0]};
    assign deg = deg_reg;
    assign sat = sat_reg;
endmodule
`default_nettype wire

>>> hdl/min_max_point_normalizer_core.sv
// min_max_point_normalizer_core: top level, ports, config and output register
// depends on mmpn_pkg, mmpn_ctrl, mmpn_dp
`timescale 1ns / 1ps
`default_nettype none
//  channel  direction  handshake                 content
//  s_axis   in         s_axis_tvalid/tready      point word, tuser = mode
//  m_axis   out        m_axis_tvalid/tready      scaled point word
//  cfg      in         cfg_valid/cfg_ready       register index and data
// a measure word is taken at once and the core stays ready; a scale word is handled
// in full before the next is taken, by one shared bit-per-cycle restoring divider
// used for each axis in turn (product, load, 2*(CW+1) quotient bits, write back)
// the result sits in an output register; the next word is taken while it waits
// reset clears min/max state and sets target range to [0, 1.0]
module min_max_point_normalizer_core #(
    parameter int COORD_WIDTH   = mmpn_pkg::COORD_WIDTH,
    parameter int FRACTION_BITS = mmpn_pkg::FRACTION_BITS
)
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       s_axis_tvalid,
    output logic                      s_axis_tready,
    // coord_x, coord_y, coord_z
    input  wire [3*COORD_WIDTH-1:0]   s_axis_tdata,
    // mode
    input  wire                       s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire                       m_axis_tready,
    // scaled_x, scaled_y, scaled_z, degenerate_axes, saturated_axes, zero fill
    output logic [((3*COORD_WIDTH+6+7)/8)*8-1:0] m_axis_tdata,
    input  wire                       cfg_valid,
    output logic                      cfg_ready,
    input  wire [0:0]                 cfg_index,
    input  wire [COORD_WIDTH-1:0]     cfg_data
);
    localparam int CW = COORD_WIDTH;
    localparam int OW = ((3*CW+6+7)/8)*8;

    logic [CW-1:0] tlow_reg, thigh_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlow_reg  <= '0;
            thigh_reg <= CW'(64'd1 << FRACTION_BITS);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mmpn_pkg::REG_TARGET_LOW:  tlow_reg  <= cfg_data;
                mmpn_pkg::REG_TARGET_HIGH: thigh_reg <= cfg_data;
                default: ;
            endcase
        end
    end
    assign cfg_ready = 1'b1;

    mmpn_pkg::mmpn_cmd_t  cmd;
    mmpn_pkg::mmpn_stat_t stat;
    logic                 out_load;
    logic [3*CW-1:0]      res;
    logic [2:0]           deg, sat;

    mmpn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_mode  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .out_busy (m_axis_tvalid && !m_axis_tready),
        .out_load (out_load),
        .stat     (stat),
        .cmd      (cmd)
    );

    mmpn_dp #(.COORD_WIDTH(CW)) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .px    (s_axis_tdata[CW-1:0]),
        .py    (s_axis_tdata[2*CW-1:CW]),
        .pz    (s_axis_tdata[3*CW-1:2*CW]),
        .tlow  (tlow_reg),
        .thigh (thigh_reg),
        .res   (res),
        .deg   (deg),
        .sat   (sat)
    );

    logic          ovalid_reg;
    logic [OW-1:0] odata_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (out_load)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end
    always_ff @(posedge clk)
    begin
        if (out_load)
            odata_reg <= OW'({sat, deg, res});
    end
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
endmodule
`default_nettype wire

>>> bench/tb_min_max_point_normalizer_core.sv
// tb_min_max_point_normalizer_core: self-checking bench for the min-max point normaliser
// depends on mmpn_pkg and min_max_point_normalizer_core; random stimulus, scoreboard class
`timescale 1ns / 1ps
module tb_min_max_point_normalizer_core;
    localparam int CW    = mmpn_pkg::COORD_WIDTH;
    localparam int OUT_W = ((3*CW+6+7)/8)*8;

    typedef struct packed {
        logic [2:0]          sat;
        logic [2:0]          deg;
        logic signed [CW-1:0] z;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] x;
    } scaled_point_t;

    class point_scoreboard;
        longint lo_v[3];
        longint hi_v[3];
        longint tgt_low;
        longint tgt_high;
        bit     nonempty;
        bit     last_scale;
        scaled_point_t pending[$];
        int     errors;

        function void clear();
            for (int i = 0; i < 3; i++)
            begin
                lo_v[i] = 0;
                hi_v[i] = 0;
            end
            tgt_low    = 0;
            tgt_high   = 65536;
            nonempty   = 0;
            last_scale = 1;
            errors     = 0;
            pending.delete();
        endfunction

        function void set_target(logic [0:0] idx, logic [CW-1:0] val);
            if (idx == mmpn_pkg::REG_TARGET_LOW)
                tgt_low = longint'($signed(val));
            else
                tgt_high = longint'($signed(val));
        endfunction

        // exact wide arithmetic; 128-bit signed holds every product
        function automatic logic [CW-1:0] rescale(longint p, longint lo, longint hi,
                                                  int ax, ref logic [2:0] deg,
                                                  ref logic [2:0] sat);
            logic signed [127:0] prod;
            logic signed [127:0] quot;
            logic signed [127:0] res;
            longint maxv;
            longint minv;
            maxv = (longint'(1) <<< (CW-1)) - 1;
            minv = -(longint'(1) <<< (CW-1));
            if (!nonempty || hi <= lo)
            begin
                deg[ax] = 1'b1;
                return tgt_low[CW-1:0];
            end
            prod = 128'(p - lo) * 128'(tgt_high - tgt_low);
            quot = prod / 128'(hi - lo);   // truncates toward zero
            res  = 128'(tgt_low) + quot;
            if (res > 128'(maxv))
            begin
                sat[ax] = 1'b1;
                res = 128'(maxv);
            end
            else if (res < 128'(minv))
            begin
                sat[ax] = 1'b1;
                res = 128'(minv);
            end
            return res[CW-1:0];
        endfunction

        function void note_point(logic mode, logic [3*CW-1:0] data);
            longint c[3];
            scaled_point_t e;
            logic [2:0] deg;
            logic [2:0] sat;
            logic [CW-1:0] r[3];
            for (int i = 0; i < 3; i++)
                c[i] = longint'($signed(data[i*CW +: CW]));
            if (mode == mmpn_pkg::MODE_MEASURE)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (last_scale || !nonempty)
                    begin
                        lo_v[i] = c[i];
                        hi_v[i] = c[i];
                    end
                    else
                    begin
                        if (c[i] < lo_v[i]) lo_v[i] = c[i];
                        if (c[i] > hi_v[i]) hi_v[i] = c[i];
                    end
                end
                nonempty   = 1;
                last_scale = 0;
                return;
            end
            last_scale = 1;
            deg = '0;
            sat = '0;
            for (int i = 0; i < 3; i++)
                r[i] = rescale(c[i], lo_v[i], hi_v[i], i, deg, sat);
            e.x = r[0];
            e.y = r[1];
            e.z = r[2];
            e.deg = deg;
            e.sat = sat;
            pending.push_back(e);
        endfunction

        function void check_result(logic [OUT_W-1:0] word);
            scaled_point_t got;
            scaled_point_t exp_p;
            got = word[3*CW+5:0];
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            exp_p = pending.pop_front();
            if (got.x !== exp_p.x)
                $display("%0t: scaled_x expected %h actual %h", $realtime, exp_p.x, got.x);
            if (got.y !== exp_p.y)
                $display("%0t: scaled_y expected %h actual %h", $realtime, exp_p.y, got.y);
            if (got.z !== exp_p.z)
                $display("%0t: scaled_z expected %h actual %h", $realtime, exp_p.z, got.z);
            if (got.deg !== exp_p.deg)
                $display("%0t: degenerate_axes expected %b actual %b", $realtime,
                         exp_p.deg, got.deg);
            if (got.sat !== exp_p.sat)
                $display("%0t: saturated_axes expected %b actual %b", $realtime,
                         exp_p.sat, got.sat);
            if (got !== exp_p)
                errors++;
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [3*CW-1:0]   s_axis_tdata;
    logic              s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [0:0]        cfg_index;
    logic [CW-1:0]     cfg_data;

    point_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_cycles;

    min_max_point_normalizer_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver: random stall, plus one long hold-off
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(logic [0:0] idx, logic [CW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_target(idx, val);
    endtask

    task automatic send_point(logic mode, logic [CW-1:0] x, logic [CW-1:0] y,
                              logic [CW-1:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {z, y, x};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_point(mode, {z, y, x});
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        // every scale result has been checked once pending is empty; then a further wait
        repeat (3*(2*CW+6) + 20) @(posedge clk);
    endtask

    function automatic logic [CW-1:0] rnd_coord();
        case ($urandom_range(5))
            0: return {1'b0, {(CW-1){1'b1}}};
            1: return {1'b1, {(CW-1){1'b0}}};
            2: return CW'($urandom_range(2000)) - CW'(1000);
            3: return CW'($signed(CW'($urandom_range(200000)) - CW'(100000))) <<< 8;
            default: return $urandom;
        endcase
    endfunction

    // well-formed set: up to six measures (sometimes none) then one to five scales, some points out of range
    task automatic random_set(ref int count);
        int nm;
        int ns;
        nm = $urandom_range(1, 6);
        ns = $urandom_range(1, 5);
        if ($urandom_range(9) == 0) nm = 0;
        for (int i = 0; i < nm; i++)
        begin
            send_point(mmpn_pkg::MODE_MEASURE, rnd_coord(), rnd_coord(), rnd_coord());
            count++;
        end
        for (int i = 0; i < ns; i++)
        begin
            send_point(mmpn_pkg::MODE_SCALE, rnd_coord(), rnd_coord(), rnd_coord());
            count++;
        end
    endtask

    task automatic run_phase(int n_items);
        int count;
        count = 0;
        while (count < n_items)
            random_set(count);
    endtask

    initial
    begin
        logic [CW-1:0] maxc;
        logic [CW-1:0] minc;
        sb = new();
        sb.clear();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = mmpn_pkg::MODE_MEASURE;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = mmpn_pkg::REG_TARGET_LOW;
        cfg_data      = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 0;
        maxc = {1'b0, {(CW-1){1'b1}}};
        minc = {1'b1, {(CW-1){1'b0}}};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset range, nothing measured, zero span, extremes, overflow
        send_point(mmpn_pkg::MODE_SCALE, 32'h1234, maxc, minc);
        send_point(mmpn_pkg::MODE_MEASURE, 32'h0, 32'h10000, 32'h5);
        send_point(mmpn_pkg::MODE_SCALE, 32'h0, 32'h10000, 32'h5);
        send_point(mmpn_pkg::MODE_MEASURE, minc, minc, 32'h0);
        send_point(mmpn_pkg::MODE_MEASURE, maxc, 32'hffff_0000, 32'h0);
        send_point(mmpn_pkg::MODE_SCALE, maxc, minc, 32'h0);
        send_point(mmpn_pkg::MODE_SCALE, 32'h0, 32'hffff_0000, maxc);
        send_point(mmpn_pkg::MODE_SCALE, minc, maxc, minc);
        go_idle();
        write_reg(mmpn_pkg::REG_TARGET_LOW, minc);
        write_reg(mmpn_pkg::REG_TARGET_HIGH, maxc);
        send_point(mmpn_pkg::MODE_SCALE, maxc, minc, 32'h1);
        send_point(mmpn_pkg::MODE_MEASURE, 32'h0, 32'h0, 32'h0);
        send_point(mmpn_pkg::MODE_MEASURE, 32'h10, 32'h1, 32'h0);
        send_point(mmpn_pkg::MODE_SCALE, maxc, minc, 32'h8);
        go_idle();
        // reversed range
        write_reg(mmpn_pkg::REG_TARGET_LOW, maxc);
        write_reg(mmpn_pkg::REG_TARGET_HIGH, minc);
        send_point(mmpn_pkg::MODE_SCALE, 32'h8, 32'h0, minc);
        send_point(mmpn_pkg::MODE_SCALE, maxc, 32'h1, 32'h0);
        go_idle();
        // empty range
        write_reg(mmpn_pkg::REG_TARGET_LOW, 32'h0003_0000);
        write_reg(mmpn_pkg::REG_TARGET_HIGH, 32'h0003_0000);
        send_point(mmpn_pkg::MODE_SCALE, 32'h4, 32'h1, maxc);
        go_idle();

        // random phases, target range changed between them
        send_idle_pct = 12;
        recv_idle_pct = 71;
        write_reg(mmpn_pkg::REG_TARGET_LOW, 32'h0);
        write_reg(mmpn_pkg::REG_TARGET_HIGH, 32'h0001_0000);
        run_phase(350);
        go_idle();
        write_reg(mmpn_pkg::REG_TARGET_LOW, $urandom);
        write_reg(mmpn_pkg::REG_TARGET_HIGH, $urandom);
        hold_cycles = 600;
        run_phase(100);
        go_idle();
        send_idle_pct = 71;
        recv_idle_pct = 12;
        write_reg(mmpn_pkg::REG_TARGET_LOW, 32'hffff_0000);
        write_reg(mmpn_pkg::REG_TARGET_HIGH, 32'h0001_0000);
        run_phase(350);
        go_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(mmpn_pkg::REG_TARGET_LOW, $urandom);
        write_reg(mmpn_pkg::REG_TARGET_HIGH, $urandom);
        run_phase(300);
        go_idle();
        write_reg(mmpn_pkg::REG_TARGET_LOW, minc);
        write_reg(mmpn_pkg::REG_TARGET_HIGH, maxc);
        run_phase(280);
        go_idle();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog for about 1400 words under stalls, with a wide margin
    initial
    begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
